### rtl/qdsr_pkg.sv
// Shared types, constants and the transition table for the dual quadrature decoder.
// No dependencies; every module in rtl/ imports this package.
package qdsr_pkg;

    localparam int unsigned PosW  = 32;
    localparam int unsigned TimeW = 32;
    localparam int unsigned PinW  = 2;
    localparam int unsigned StepW = 3;

    localparam logic [TimeW-1:0] GapReset = 32'd500;

    localparam logic signed [StepW-1:0] StepSkip = 3'sd2;

    typedef logic signed [StepW-1:0] t_step;
    typedef logic [PinW-1:0]         t_pins;

    // Per-encoder status handed to the top level on each processed word.
    typedef struct packed {
        logic                   significant;
        logic signed [PosW-1:0] position;
    } t_trk_status;

    // Raw step for an old/new pin pair; 2 marks a skipped (double) transition.
    function automatic t_step step_lookup(input t_pins old_pins, input t_pins new_pins);
        t_step s;
        case ({old_pins, new_pins})
            4'd0:    s = 3'sd0;
            4'd1:    s = 3'sd1;
            4'd2:    s = -3'sd1;
            4'd3:    s = 3'sd2;
            4'd4:    s = -3'sd1;
            4'd5:    s = 3'sd0;
            4'd6:    s = 3'sd2;
            4'd7:    s = 3'sd1;
            4'd8:    s = 3'sd1;
            4'd9:    s = 3'sd2;
            4'd10:   s = 3'sd0;
            4'd11:   s = -3'sd1;
            4'd12:   s = 3'sd2;
            4'd13:   s = -3'sd1;
            4'd14:   s = 3'sd1;
            4'd15:   s = 3'sd0;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/qdsr_track.sv
// One encoder channel: step lookup, skip/reversal correction, position and history.
// Depends on qdsr_pkg.
module qdsr_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  qdsr_pkg::t_pins              i_pins,
    input  logic [qdsr_pkg::TimeW-1:0]   i_now_us,
    input  logic [qdsr_pkg::TimeW-1:0]   i_gap_threshold_us,
    output qdsr_pkg::t_trk_status        o_status
);
    import qdsr_pkg::*;

    t_pins                   r_last_pins;
    logic [TimeW-1:0]        r_last_time;
    t_step                   r_p1;
    t_step                   r_p2;
    logic signed [PosW-1:0]  r_position;

    logic                    w_changed;
    logic                    w_sig;
    logic [TimeW-1:0]        w_elapsed;
    logic signed [StepW:0]   w_sum;
    t_step                   w_raw;
    t_step                   w_step;
    logic signed [PosW-1:0]  n_position;

    always_comb begin
        w_changed = i_pins != r_last_pins;
        w_elapsed = i_now_us - r_last_time;
        w_sig     = w_changed && (w_elapsed > i_gap_threshold_us);
        w_sum     = {r_p1[StepW-1], r_p1} + {r_p2[StepW-1], r_p2};
        w_raw     = step_lookup(r_last_pins, i_pins);
        w_step    = w_raw;
        if (w_raw == StepSkip) begin
            if (r_p1 < 0 && r_p2 < 0) begin
                w_step = -3'sd2;
            end else if (r_p1 <= 0 || r_p2 <= 0) begin
                w_step = 3'sd0;
            end
        end else if (w_sum > 4'sd2 && w_raw == -3'sd1) begin
            w_step = 3'sd3;
        end else if (w_sum < -4'sd2 && w_raw == 3'sd1) begin
            w_step = -3'sd3;
        end
        n_position = w_changed ? r_position + PosW'(w_step) : r_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pins <= '0;
            r_last_time <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_position  <= '0;
        end else if (i_advance && w_changed) begin
            r_last_pins <= i_pins;
            r_last_time <= i_now_us;
            r_position  <= n_position;
            if (w_sig) begin
                r_p2 <= r_p1;
                r_p1 <= w_step;
            end
        end
    end

    assign o_status.significant = w_sig;
    assign o_status.position    = n_position;

endmodule

### rtl/dual_quadrature_decoder_skip_recovery.sv
// Top level of the dual quadrature decoder with skipped-step recovery.
// Depends on qdsr_pkg and qdsr_track (one instance per encoder).
//
// Each input word is one sample of two encoders' A/B pins plus a microsecond
// timestamp. The word is captured in an input register; when the output
// register is free or draining, the two channel trackers look up the step,
// correct skipped and reversed steps from the two recorded earlier steps and
// update position. When either encoder changed after more than
// gap_threshold_us microseconds (elapsed time taken modulo 2^32), one output
// word carrying both positions is loaded into the output register; otherwise
// the sample yields no output. A word is accepted every cycle while the
// output side keeps up; each word passes through the input register, the
// single table-lookup-and-add pass and the output register. Write the
// threshold only while the block is idle; its port is always ready.
module dual_quadrature_decoder_skip_recovery (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qdsr_pkg::TimeW-1:0]          i_cfg_gap_threshold_us,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [qdsr_pkg::PinW-1:0]           i_pins_0,
    input  logic [qdsr_pkg::PinW-1:0]           i_pins_1,
    input  logic [qdsr_pkg::TimeW-1:0]          i_now_us,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [qdsr_pkg::PosW-1:0]    o_position_0,
    output logic signed [qdsr_pkg::PosW-1:0]    o_position_1
);
    import qdsr_pkg::*;

    logic [TimeW-1:0]       r_gap;
    logic                   r_in_valid;
    t_pins                  r_pins_0;
    t_pins                  r_pins_1;
    logic [TimeW-1:0]       r_now;
    logic                   r_out_valid;
    logic signed [PosW-1:0] r_pos_0;
    logic signed [PosW-1:0] r_pos_1;

    logic                   w_fire;
    logic                   w_any;
    t_trk_status            w_st_0;
    t_trk_status            w_st_1;

    // Process the held word when the output register is free or draining.
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign w_any       = w_st_0.significant || w_st_1.significant;
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GapReset;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_gap_threshold_us;
        end
    end

    // Input register: hold the word until the trackers consume it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pins_0 <= i_pins_0;
            r_pins_1 <= i_pins_1;
            r_now    <= i_now_us;
        end
    end

    qdsr_track u_trk_0 (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_fire),
        .i_pins             (r_pins_0),
        .i_now_us           (r_now),
        .i_gap_threshold_us (r_gap),
        .o_status           (w_st_0)
    );

    qdsr_track u_trk_1 (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_fire),
        .i_pins             (r_pins_1),
        .i_now_us           (r_now),
        .i_gap_threshold_us (r_gap),
        .o_status           (w_st_1)
    );

    // Output register: load on a significant change, drop the word otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_any;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_any) begin
            r_pos_0 <= w_st_0.position;
            r_pos_1 <= w_st_1.position;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position_0 = r_pos_0;
    assign o_position_1 = r_pos_1;

    // Never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !w_fire)
        else $error("result overwritten while stalled");

    // A significant change always produces a result next cycle.
    a_result_on_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_any |=> r_out_valid)
        else $error("significant change lost");

    // A processed word without a significant change leaves no result behind.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_any |=> !r_out_valid)
        else $error("result without significant change");

    // An empty input register always takes a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled while empty");

endmodule
